// ===== rtl/core/ppm_pkg.sv =====
// shared types, constants and register codes for the ppm decoder and arm gesture block
// no dependencies; imported by every module of the block
package ppm_pkg;

    // channel store geometry
    localparam int NUM_CHANNELS = 8;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int CH_CNT_W     = $clog2(NUM_CHANNELS + 1);
    localparam int THR_CH       = 2;
    localparam int YAW_CH       = 3;

    // field widths
    localparam int TIME_W  = 16;
    localparam int VALUE_W = 12;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 16;

    // pulse acceptance limits, open interval
    localparam logic [TIME_W-1:0] PULSE_MIN = 16'd900;
    localparam logic [TIME_W-1:0] PULSE_MAX = 16'd2100;

    // channel store reset contents
    localparam logic [VALUE_W-1:0] CH_RESET  = 12'd1500;
    localparam logic [VALUE_W-1:0] THR_RESET = 12'd1000;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW_CENTER     = 3'd0,
        CFG_THROTTLE_LIMIT = 3'd1,
        CFG_ARM_YAW_MIN    = 3'd2,
        CFG_DISARM_YAW_MAX = 3'd3,
        CFG_CENTER_WINDOW  = 3'd4,
        CFG_HOLD_TICKS     = 3'd5,
        CFG_SYNC_GAP       = 3'd6
    } cfg_index_t;

    typedef enum logic {
        KIND_CAPTURE = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef struct packed {
        logic [10:0] yaw_center;
        logic [11:0] throttle_limit;
        logic [11:0] arm_yaw_min;
        logic [11:0] disarm_yaw_max;
        logic [8:0]  center_window;
        logic [9:0]  hold_ticks;
        logic [15:0] sync_gap;
    } cfg_t;

    // classified item, as held in the queue
    typedef struct packed {
        kind_t             kind;
        logic              armed_state;
        logic              is_sync;
        logic              pulse_ok;
        logic [TIME_W-1:0] interval;
    } item_t;

    typedef struct packed {
        logic               arm_request;
        logic               disarm_request;
        logic               yaw_centered_flag;
        logic               frame_sync;
        logic               channel_written;
        logic [INDEX_W-1:0] channel_index;
        logic [TIME_W-1:0]  pulse_width;
        logic [VALUE_W-1:0] throttle_value;
        logic [VALUE_W-1:0] yaw_value;
    } result_t;

endpackage

// ===== rtl/core/ppm_front.sv =====
// front end: accepts items, forms the edge interval and classifies it
// depends on ppm_pkg
module ppm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ppm_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [ppm_pkg::TIME_W-1:0] capture_time,
    input  logic                       armed_state,
    output logic                       push,
    output ppm_pkg::item_t             push_item,
    input  logic                       queue_full
);
    import ppm_pkg::*;

    logic [TIME_W-1:0] prev_edge_reg;
    logic [TIME_W-1:0] prev_edge_next;
    logic [TIME_W-1:0] interval;
    kind_t             item_kind;

    assign item_kind = kind_t'(kind);
    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;

    // subtraction wraps modulo the timer width
    assign interval = capture_time - prev_edge_reg;

    always_comb
    begin
        push_item.kind        = item_kind;
        push_item.armed_state = armed_state;
        push_item.interval    = interval;
        push_item.is_sync     = interval > cfg.sync_gap;
        push_item.pulse_ok    = (interval > PULSE_MIN) && (interval < PULSE_MAX);
        prev_edge_next        = prev_edge_reg;
        if (push && item_kind == KIND_CAPTURE)
        begin
            prev_edge_next = capture_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg <= '0;
        end
        else
        begin
            prev_edge_reg <= prev_edge_next;
        end
    end

endmodule

// ===== rtl/core/ppm_queue.sv =====
// two entry queue between the classifying front end and the executing back end
// depends on ppm_pkg
module ppm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppm_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ppm_pkg::item_t head_item
);
    import ppm_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/ppm_back.sv =====
// back end: channel store, frame position, arm and disarm gesture state, result register
// depends on ppm_pkg
module ppm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ppm_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  ppm_pkg::item_t  head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output ppm_pkg::result_t result
);
    import ppm_pkg::*;

    logic [VALUE_W-1:0]  store_reg  [NUM_CHANNELS];
    logic [VALUE_W-1:0]  store_next [NUM_CHANNELS];
    logic [CH_CNT_W-1:0] next_ch_reg;
    logic [CH_CNT_W-1:0] next_ch_next;
    logic [COUNT_W-1:0]  arm_cnt_reg;
    logic [COUNT_W-1:0]  arm_cnt_next;
    logic [COUNT_W-1:0]  disarm_cnt_reg;
    logic [COUNT_W-1:0]  disarm_cnt_next;
    logic                centered_reg;
    logic                centered_next;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res_next;

    logic [VALUE_W-1:0]  thr;
    logic [VALUE_W-1:0]  yaw;
    logic                thr_low;
    logic signed [13:0]  win_lo;
    logic signed [13:0]  win_hi;
    logic                in_window;
    logic                armed_eff;
    logic [COUNT_W-1:0]  arm_inc;
    logic [COUNT_W-1:0]  disarm_inc;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    assign thr     = store_reg[THR_CH];
    assign yaw     = store_reg[YAW_CH];
    assign thr_low = thr < cfg.throttle_limit;

    // open window around the centre, lower bound may go negative
    assign win_lo    = $signed({3'b000, cfg.yaw_center}) - $signed({5'b00000, cfg.center_window});
    assign win_hi    = $signed({3'b000, cfg.yaw_center}) + $signed({5'b00000, cfg.center_window});
    assign in_window = ($signed({2'b00, yaw}) > win_lo) && ($signed({2'b00, yaw}) < win_hi);

    assign arm_inc    = arm_cnt_reg + 1'b1;
    assign disarm_inc = disarm_cnt_reg + 1'b1;

    always_comb
    begin
        store_next      = store_reg;
        next_ch_next    = next_ch_reg;
        arm_cnt_next    = arm_cnt_reg;
        disarm_cnt_next = disarm_cnt_reg;
        centered_next   = centered_reg;
        armed_eff       = head_item.armed_state;
        res_next        = '0;

        if (head_item.kind == KIND_CAPTURE)
        begin
            res_next.pulse_width = head_item.interval;
            if (head_item.is_sync)
            begin
                next_ch_next       = '0;
                res_next.frame_sync = 1'b1;
            end
            else if (next_ch_reg < CH_CNT_W'(NUM_CHANNELS))
            begin
                if (head_item.pulse_ok)
                begin
                    store_next[next_ch_reg[CH_IDX_W-1:0]] = head_item.interval[VALUE_W-1:0];
                    res_next.channel_written = 1'b1;
                    res_next.channel_index   = INDEX_W'(next_ch_reg[CH_IDX_W-1:0]);
                end
                next_ch_next = next_ch_reg + 1'b1;
            end
        end
        else
        begin
            if (!head_item.armed_state)
            begin
                centered_next = 1'b0;
                if (thr_low && yaw > cfg.arm_yaw_min)
                begin
                    arm_cnt_next = arm_inc;
                    if (arm_inc > COUNT_W'(cfg.hold_ticks))
                    begin
                        res_next.arm_request = 1'b1;
                        arm_cnt_next         = '0;
                        armed_eff            = 1'b1;
                    end
                end
                else
                begin
                    arm_cnt_next = '0;
                end
            end
            // armed branch also runs on the tick that commands arming
            if (armed_eff)
            begin
                if (thr_low && in_window)
                begin
                    centered_next = 1'b1;
                end
                if (thr_low && yaw < cfg.disarm_yaw_max)
                begin
                    disarm_cnt_next = disarm_inc;
                    if (disarm_inc > COUNT_W'(cfg.hold_ticks))
                    begin
                        res_next.disarm_request = 1'b1;
                        centered_next           = 1'b0;
                        disarm_cnt_next         = '0;
                    end
                end
                else
                begin
                    disarm_cnt_next = '0;
                end
            end
        end

        res_next.yaw_centered_flag = centered_next;
        res_next.throttle_value    = store_next[THR_CH];
        res_next.yaw_value         = store_next[YAW_CH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= (i == THR_CH) ? THR_RESET : CH_RESET;
            end
            next_ch_reg    <= '0;
            arm_cnt_reg    <= '0;
            disarm_cnt_reg <= '0;
            centered_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                store_reg      <= store_next;
                next_ch_reg    <= next_ch_next;
                arm_cnt_reg    <= arm_cnt_next;
                disarm_cnt_reg <= disarm_cnt_next;
                centered_reg   <= centered_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/ppm_decoder_with_arm_gesture.sv =====
// top level of the ppm decoder with stick gesture arm and disarm
// depends on ppm_pkg, ppm_front, ppm_queue, ppm_back
//
//  channel  handshake             payload
//  in       in_valid / in_ready   kind, capture_time, armed_state
//  out      out_valid / out_ready arm_request .. yaw_value (one transaction per input)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// one item per cycle sustained while the output does not stall; an accepted item is
// registered in a queue slot and then in the result register before it shows at the
// output (front end into the queue, back end into the result register)
// the back end's state update sets the rate: store, counters, flag
// reset loads the channel store defaults and the register reset values at once
// an output stall fills the two entry queue; in_ready drops only when it is full
module ppm_decoder_with_arm_gesture (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [ppm_pkg::TIME_W-1:0]     capture_time,
    input  logic                           armed_state,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           arm_request,
    output logic                           disarm_request,
    output logic                           yaw_centered_flag,
    output logic                           frame_sync,
    output logic                           channel_written,
    output logic [ppm_pkg::INDEX_W-1:0]    channel_index,
    output logic [ppm_pkg::TIME_W-1:0]     pulse_width,
    output logic [ppm_pkg::VALUE_W-1:0]    throttle_value,
    output logic [ppm_pkg::VALUE_W-1:0]    yaw_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppm_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    push;
    item_t   push_item;
    logic    queue_full;
    logic    pop;
    logic    head_valid;
    item_t   head_item;
    result_t result;

    // register writes keep only each register's width; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_YAW_CENTER:     cfg_next.yaw_center     = cfg_data[10:0];
                CFG_THROTTLE_LIMIT: cfg_next.throttle_limit = cfg_data[11:0];
                CFG_ARM_YAW_MIN:    cfg_next.arm_yaw_min    = cfg_data[11:0];
                CFG_DISARM_YAW_MAX: cfg_next.disarm_yaw_max = cfg_data[11:0];
                CFG_CENTER_WINDOW:  cfg_next.center_window  = cfg_data[8:0];
                CFG_HOLD_TICKS:     cfg_next.hold_ticks     = cfg_data[9:0];
                CFG_SYNC_GAP:       cfg_next.sync_gap       = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_center     <= 11'd1500;
            cfg_reg.throttle_limit <= 12'd1050;
            cfg_reg.arm_yaw_min    <= 12'd1850;
            cfg_reg.disarm_yaw_max <= 12'd1150;
            cfg_reg.center_window  <= 9'd80;
            cfg_reg.hold_ticks     <= 10'd50;
            cfg_reg.sync_gap       <= 16'd3000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // interval and classification
    ppm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .capture_time (capture_time),
        .armed_state  (armed_state),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    // decouples the front end from result stalls
    ppm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // channel store and gesture state
    ppm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign arm_request       = result.arm_request;
    assign disarm_request    = result.disarm_request;
    assign yaw_centered_flag = result.yaw_centered_flag;
    assign frame_sync        = result.frame_sync;
    assign channel_written   = result.channel_written;
    assign channel_index     = result.channel_index;
    assign pulse_width       = result.pulse_width;
    assign throttle_value    = result.throttle_value;
    assign yaw_value         = result.yaw_value;

endmodule

// ===== test/ppm_decoder_with_arm_gesture_tb.sv =====
// testbench for the ppm decoder with stick gesture arm and disarm
// needs ppm_pkg and the ppm_decoder_with_arm_gesture rtl; checks results: typed row or predictor
`timescale 1ns / 100ps

module ppm_decoder_with_arm_gesture_tb;
    import ppm_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_ITEMS    = 147;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_PHASES     = 7;

    // register index past the end of the list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one row of the directed table; interval is the gap from the last capture
    typedef struct packed {
        kind_t             kind;
        logic [TIME_W-1:0] interval;
        logic              armed;
        logic              typed;
        result_t           want;
    } stim_row_t;

    // clock, reset and block ports, all inputs known from time zero
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  kind         = 1'b0;
    logic [TIME_W-1:0]     capture_time = '0;
    logic                  armed_state  = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  arm_request;
    logic                  disarm_request;
    logic                  yaw_centered_flag;
    logic                  frame_sync;
    logic                  channel_written;
    logic [INDEX_W-1:0]    channel_index;
    logic [TIME_W-1:0]     pulse_width;
    logic [VALUE_W-1:0]    throttle_value;
    logic [VALUE_W-1:0]    yaw_value;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // sideband travelling with the input transaction: typed expectation of a table row
    logic    row_typed = 1'b0;
    result_t row_want  = '0;

    // predictor state: channel store, frame position, gesture counters, registers
    logic [VALUE_W-1:0] slot_value [NUM_CHANNELS];
    logic [4:0]         slot_ptr;
    logic [TIME_W-1:0]  last_stamp;
    logic [COUNT_W-1:0] arm_hold;
    logic [COUNT_W-1:0] disarm_hold;
    logic               yaw_centered;
    cfg_t               regs;

    // results still owed by the block, oldest first
    result_t pending_results [$];
    stim_row_t dir_rows [$];

    // stimulus control
    int                idle_pct     = 0;
    int                stall_pct    = 0;
    int                phase_count  = 0;
    int                phase_budget = 0;
    logic [TIME_W-1:0] edge_stamp   = '0;
    bit                motor_on     = 1'b0;

    // bookkeeping
    int err_count    = 0;
    int in_count     = 0;
    int result_count = 0;
    int cfg_writes   = 0;
    int idle_cycles  = 0;
    int arm_seen     = 0;
    int disarm_seen  = 0;
    int sync_seen    = 0;
    int store_seen   = 0;
    int center_seen  = 0;
    bit accepted;

    ppm_decoder_with_arm_gesture u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .capture_time      (capture_time),
        .armed_state       (armed_state),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .arm_request       (arm_request),
        .disarm_request    (disarm_request),
        .yaw_centered_flag (yaw_centered_flag),
        .frame_sync        (frame_sync),
        .channel_written   (channel_written),
        .channel_index     (channel_index),
        .pulse_width       (pulse_width),
        .throttle_value    (throttle_value),
        .yaw_value         (yaw_value),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic clear_decoder();
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            slot_value[i] = CH_RESET;
        end
        slot_value[THR_CH]  = THR_RESET;
        slot_ptr            = '0;
        last_stamp          = '0;
        arm_hold            = '0;
        disarm_hold         = '0;
        yaw_centered        = 1'b0;
        regs.yaw_center     = 11'd1500;
        regs.throttle_limit = 12'd1050;
        regs.arm_yaw_min    = 12'd1850;
        regs.disarm_yaw_max = 12'd1150;
        regs.center_window  = 9'd80;
        regs.hold_ticks     = 10'd50;
        regs.sync_gap       = 16'd3000;
    endtask

    // register write, kept to the register's width
    task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_YAW_CENTER:     regs.yaw_center     = d[10:0];
            CFG_THROTTLE_LIMIT: regs.throttle_limit = d[11:0];
            CFG_ARM_YAW_MIN:    regs.arm_yaw_min    = d[11:0];
            CFG_DISARM_YAW_MAX: regs.disarm_yaw_max = d[11:0];
            CFG_CENTER_WINDOW:  regs.center_window  = d[8:0];
            CFG_HOLD_TICKS:     regs.hold_ticks     = d[9:0];
            CFG_SYNC_GAP:       regs.sync_gap       = d[15:0];
            default: ;
        endcase
    endtask

    // one input item: capture decodes an edge, tick runs the arm / disarm gesture
    task automatic decode_item(input logic k, input logic [TIME_W-1:0] t, input logic a,
                               output result_t r);
        logic [TIME_W-1:0]  gap;
        logic               armed;
        logic [VALUE_W-1:0] thr;
        logic [VALUE_W-1:0] yaw;
        logic               low_thr;
        int                 lo;
        int                 hi;
        int                 yv;
        r = '0;
        if (k == KIND_CAPTURE)
        begin
            gap           = t - last_stamp;
            last_stamp    = t;
            r.pulse_width = gap;
            if (gap > regs.sync_gap)
            begin
                slot_ptr     = '0;
                r.frame_sync = 1'b1;
            end
            else if (slot_ptr < NUM_CHANNELS)
            begin
                // out of range pulse still uses up the slot
                if (gap > PULSE_MIN && gap < PULSE_MAX)
                begin
                    slot_value[slot_ptr[CH_IDX_W-1:0]] = gap[VALUE_W-1:0];
                    r.channel_written    = 1'b1;
                    r.channel_index      = slot_ptr[INDEX_W-1:0];
                end
                slot_ptr = slot_ptr + 1'b1;
            end
        end
        else
        begin
            armed   = a;
            thr     = slot_value[THR_CH];
            yaw     = slot_value[YAW_CH];
            low_thr = thr < regs.throttle_limit;
            // open centre window, no wrap below zero
            lo = int'(regs.yaw_center);
            hi = lo + int'(regs.center_window);
            lo = lo - int'(regs.center_window);
            yv = int'(yaw);
            if (!armed)
            begin
                yaw_centered = 1'b0;
                if (low_thr && yaw > regs.arm_yaw_min)
                begin
                    arm_hold = arm_hold + 1'b1;
                    if (arm_hold > regs.hold_ticks)
                    begin
                        r.arm_request = 1'b1;
                        arm_hold      = '0;
                        armed         = 1'b1;
                    end
                end
                else
                begin
                    arm_hold = '0;
                end
            end
            // an arm request falls through into the armed branch in the same tick
            if (armed)
            begin
                if (low_thr && yv > lo && yv < hi)
                begin
                    yaw_centered = 1'b1;
                end
                if (low_thr && yaw < regs.disarm_yaw_max)
                begin
                    disarm_hold = disarm_hold + 1'b1;
                    if (disarm_hold > regs.hold_ticks)
                    begin
                        r.disarm_request = 1'b1;
                        yaw_centered     = 1'b0;
                        disarm_hold      = '0;
                    end
                end
                else
                begin
                    disarm_hold = '0;
                end
            end
        end
        r.yaw_centered_flag = yaw_centered;
        r.throttle_value    = slot_value[THR_CH];
        r.yaw_value         = slot_value[YAW_CH];
    endtask

    // ------------------------------------------------------------------
    // result check against the oldest pending result
    // ------------------------------------------------------------------

    task automatic check_result();
        result_t got;
        result_t want;
        got.arm_request       = arm_request;
        got.disarm_request    = disarm_request;
        got.yaw_centered_flag = yaw_centered_flag;
        got.frame_sync        = frame_sync;
        got.channel_written   = channel_written;
        got.channel_index     = channel_index;
        got.pulse_width       = pulse_width;
        got.throttle_value    = throttle_value;
        got.yaw_value         = yaw_value;
        result_count++;
        arm_seen    += int'(arm_request);
        disarm_seen += int'(disarm_request);
        sync_seen   += int'(frame_sync);
        store_seen  += int'(channel_written);
        center_seen += int'(yaw_centered_flag);
        if (pending_results.size() == 0)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
            begin
                $display("error: result transaction %0d with nothing pending", result_count);
            end
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.arm_request !== want.arm_request ||
                got.disarm_request !== want.disarm_request ||
                got.yaw_centered_flag !== want.yaw_centered_flag ||
                got.frame_sync !== want.frame_sync ||
                got.channel_written !== want.channel_written ||
                got.channel_index !== want.channel_index ||
                got.pulse_width !== want.pulse_width ||
                got.throttle_value !== want.throttle_value ||
                got.yaw_value !== want.yaw_value)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at result %0d: want arm %b dis %b ctr %b sync %b",
                             result_count, want.arm_request, want.disarm_request,
                             want.yaw_centered_flag, want.frame_sync);
                    $display("  want wr %b idx %0d pw %0d thr %0d yaw %0d",
                             want.channel_written, want.channel_index, want.pulse_width,
                             want.throttle_value, want.yaw_value);
                    $display("  got  arm %b dis %b ctr %b sync %b wr %b idx %0d pw %0d",
                             got.arm_request, got.disarm_request, got.yaw_centered_flag,
                             got.frame_sync, got.channel_written, got.channel_index,
                             got.pulse_width);
                    $display("  got  thr %0d yaw %0d", got.throttle_value, got.yaw_value);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: all three channels sampled at the rising edge, plus watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        result_t pred;
        if (rst_n)
        begin
            accepted = 1'b0;
            if (out_valid && out_ready)
            begin
                accepted = 1'b1;
                check_result();
            end
            // config only moves while the block is idle
            if (cfg_valid && cfg_ready)
            begin
                accepted = 1'b1;
                cfg_writes++;
                load_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                accepted = 1'b1;
                in_count++;
                decode_item(kind, capture_time, armed_state, pred);
                if (pred.arm_request)
                begin
                    motor_on = 1'b1;
                end
                if (pred.disarm_request)
                begin
                    motor_on = 1'b0;
                end
                // table rows with a typed result are held to that value
                if (row_typed)
                begin
                    pending_results.push_back(row_want);
                end
                else
                begin
                    pending_results.push_back(pred);
                end
            end
            if (accepted)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results pending",
                         idle_cycles, pending_results.size());
                $display("FAIL ppm_decoder_with_arm_gesture");
                $finish;
            end
        end
    end

    // receiver side: random stall per cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                idle_pct  = 82;
                stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                idle_pct  = 0;
                stall_pct <= 82;
            end
            IDLE_BOTH:
            begin
                idle_pct  = 25;
                stall_pct <= 25;
            end
            default:
            begin
                idle_pct  = 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    // one input transaction; valid stays high until accepted
    task automatic send_item(input kind_t k, input logic [TIME_W-1:0] t, input logic a,
                             input logic typed, input result_t want);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        capture_time <= t;
        armed_state  <= a;
        row_typed    <= typed;
        row_want     <= want;
        do
            @(posedge clk);
        while (!in_ready);
        phase_count++;
    endtask

    task automatic send_capture(input int interval);
        edge_stamp = edge_stamp + interval[TIME_W-1:0];
        send_item(KIND_CAPTURE, edge_stamp, 1'($urandom_range(1, 0)), 1'b0, '0);
    endtask

    task automatic send_tick(input logic a);
        send_item(KIND_TICK, TIME_W'($urandom), a, 1'b0, '0);
    endtask

    // hold the sender until every pending result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [15:0] yc, thr, ay, dy, win, hold, gap);
        write_reg(CFG_YAW_CENTER, yc);
        write_reg(CFG_THROTTLE_LIMIT, thr);
        write_reg(CFG_ARM_YAW_MIN, ay);
        write_reg(CFG_DISARM_YAW_MAX, dy);
        write_reg(CFG_CENTER_WINDOW, win);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_SYNC_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_random();
        logic [15:0] gap;
        if ($urandom_range(1, 0))
        begin
            gap = 16'($urandom_range(4000, 2100));
        end
        else
        begin
            gap = 16'($urandom_range(65535, 2100));
        end
        program_regs(16'($urandom_range(1800, 1200)), 16'($urandom_range(2100, 900)),
                     16'($urandom_range(2100, 900)), 16'($urandom_range(2100, 900)),
                     16'($urandom_range(400, 0)), 16'($urandom_range(12, 0)), gap);
    endtask

    // a pulse width clipped to what the channel store keeps
    function automatic int pick_pulse(input int lo, input int hi);
        if (lo < 901)
        begin
            lo = 901;
        end
        if (hi > 2099)
        begin
            hi = 2099;
        end
        if (lo > hi)
        begin
            return $urandom_range(2099, 901);
        end
        return $urandom_range(hi, lo);
    endfunction

    // sync gap unless sync_gap is 65535, then slots, at times short, long or with a bad pulse
    task automatic send_frame(input int thr_v, input int yaw_v);
        int n;
        int iv;
        if (regs.sync_gap != 16'hFFFF)
        begin
            send_capture($urandom_range(65535, regs.sync_gap + 1));
        end
        if ($urandom_range(99, 0) < 75)
        begin
            n = NUM_CHANNELS;
        end
        else
        begin
            n = $urandom_range(NUM_CHANNELS + 2, 1);
        end
        for (int s = 0; s < n; s++)
        begin
            if ($urandom_range(99, 0) < 8)
            begin
                case ($urandom_range(3, 0))
                    0:       iv = int'(PULSE_MIN);
                    1:       iv = int'(PULSE_MAX);
                    2:       iv = $urandom_range(900, 0);
                    default: iv = $urandom_range(regs.sync_gap, 2100);
                endcase
            end
            else if (s == THR_CH)
            begin
                iv = thr_v;
            end
            else if (s == YAW_CH)
            begin
                iv = yaw_v;
            end
            else
            begin
                iv = $urandom_range(2099, 901);
            end
            send_capture(iv);
        end
    endtask

    // sticks held in one position over a few frames, with ticks in between
    task automatic run_episode();
        int thr_v;
        int yaw_v;
        int yc;
        int win;
        int r;
        int frames;
        int max_ticks;
        yc  = int'(regs.yaw_center);
        win = int'(regs.center_window);
        if ($urandom_range(99, 0) < 70)
        begin
            thr_v = pick_pulse(901, int'(regs.throttle_limit) - 1);
        end
        else
        begin
            thr_v = pick_pulse(int'(regs.throttle_limit), 2099);
        end
        r = $urandom_range(99, 0);
        // armed motors lean toward centre and disarm, disarmed toward arm
        if (motor_on)
        begin
            if (r < 45)
                yaw_v = pick_pulse(901, int'(regs.disarm_yaw_max) - 1);
            else if (r < 80)
                yaw_v = pick_pulse(yc - win + 1, yc + win - 1);
            else
                yaw_v = $urandom_range(2099, 901);
        end
        else
        begin
            if (r < 55)
                yaw_v = pick_pulse(int'(regs.arm_yaw_min) + 1, 2099);
            else if (r < 70)
                yaw_v = pick_pulse(yc - win + 1, yc + win - 1);
            else if (r < 85)
                yaw_v = pick_pulse(901, int'(regs.disarm_yaw_max) - 1);
            else
                yaw_v = $urandom_range(2099, 901);
        end
        max_ticks = int'(regs.hold_ticks) / 3 + 4;
        if (max_ticks > 40)
        begin
            max_ticks = 40;
        end
        frames = $urandom_range(6, 1);
        for (int f = 0; f < frames && phase_count < phase_budget; f++)
        begin
            if ($urandom_range(99, 0) < 10)
            begin
                // noise: arbitrary timestamps and motor states
                repeat ($urandom_range(4, 1))
                begin
                    if ($urandom_range(1, 0))
                    begin
                        edge_stamp = TIME_W'($urandom);
                        send_item(KIND_CAPTURE, edge_stamp, 1'($urandom_range(1, 0)),
                                  1'b0, '0);
                    end
                    else
                    begin
                        send_tick(1'($urandom_range(1, 0)));
                    end
                end
            end
            else
            begin
                send_frame(thr_v, yaw_v);
            end
            repeat ($urandom_range(max_ticks, 1))
            begin
                if ($urandom_range(99, 0) < 90)
                    send_tick(motor_on);
                else
                    send_tick(1'($urandom_range(1, 0)));
            end
        end
    endtask

    task automatic run_random(input bit pause_midway);
        bit paused;
        paused       = 1'b0;
        phase_count  = 0;
        phase_budget = PHASE_ITEMS;
        while (phase_count < phase_budget)
        begin
            if (pause_midway && !paused && phase_count >= phase_budget / 2)
            begin
                paused = 1'b1;
                drain();
            end
            run_episode();
        end
    endtask

    function automatic result_t mk_res(input logic a, input logic d, input logic c,
                                       input logic s, input logic w,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic [TIME_W-1:0] pw,
                                       input logic [VALUE_W-1:0] thr,
                                       input logic [VALUE_W-1:0] yaw);
        result_t r;
        r.arm_request       = a;
        r.disarm_request    = d;
        r.yaw_centered_flag = c;
        r.frame_sync        = s;
        r.channel_written   = w;
        r.channel_index     = idx;
        r.pulse_width       = pw;
        r.throttle_value    = thr;
        r.yaw_value         = yaw;
        return r;
    endfunction

    task automatic add_row(input kind_t k, input logic [TIME_W-1:0] iv, input logic a,
                           input logic typed, input result_t want);
        stim_row_t row;
        row.kind     = k;
        row.interval = iv;
        row.armed    = a;
        row.typed    = typed;
        row.want     = want;
        dir_rows.push_back(row);
    endtask

    // directed table at reset register values
    task automatic build_rows();
        // reset state, then the centre window catching yaw 1500 on an armed tick
        add_row(KIND_TICK, 16'd0, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0, 12'd1000, 12'd1500));
        add_row(KIND_TICK, 16'd0, 1'b1, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'd0, 12'd1000, 12'd1500));
        // widest interval is a sync, then the timer wraps to an interval of one
        add_row(KIND_CAPTURE, 16'd65535, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 16'd65535, 12'd1000, 12'd1500));
        add_row(KIND_CAPTURE, 16'd1, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'd1, 12'd1000, 12'd1500));
        // pulse limits are open: 901 and 2099 kept, 900 and 2100 rejected but slot used
        add_row(KIND_CAPTURE, 16'd901, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, 16'd901, 12'd1000, 12'd1500));
        add_row(KIND_CAPTURE, 16'd900, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'd900, 12'd1000, 12'd1500));
        add_row(KIND_CAPTURE, 16'd2099, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 4'd3, 16'd2099, 12'd1000, 12'd2099));
        add_row(KIND_CAPTURE, 16'd2100, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'd2100, 12'd1000, 12'd2099));
        // sync threshold is strict
        add_row(KIND_CAPTURE, 16'd3000, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 16'd3000, 12'd1000, 12'd2099));
        add_row(KIND_CAPTURE, 16'd3001, 1'b0, 1'b1,
                mk_res(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 16'd3001, 12'd1000, 12'd2099));
        // a full frame, then one more pulse that the full frame ignores
        add_row(KIND_CAPTURE, 16'd1000, 1'b0, 1'b0, '0);
        add_row(KIND_CAPTURE, 16'd1100, 1'b0, 1'b0, '0);
        add_row(KIND_CAPTURE, 16'd1000, 1'b0, 1'b0, '0);
        add_row(KIND_CAPTURE, 16'd1900, 1'b0, 1'b0, '0);
        repeat (NUM_CHANNELS - 4)
        begin
            add_row(KIND_CAPTURE, 16'd1500, 1'b0, 1'b0, '0);
        end
        add_row(KIND_CAPTURE, 16'd1200, 1'b0, 1'b0, '0);
        // arm gesture starts counting, armed tick off centre
        add_row(KIND_TICK, 16'd0, 1'b0, 1'b0, '0);
        add_row(KIND_TICK, 16'd0, 1'b1, 1'b0, '0);
        add_row(KIND_TICK, 16'd0, 1'b0, 1'b0, '0);
        add_row(KIND_CAPTURE, 16'd65535, 1'b0, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : driver
        logic [15:0] raw_center;
        clear_decoder();
        build_rows();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 0: table then random, reset registers, no idling
        set_idle(IDLE_NONE);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == KIND_CAPTURE)
            begin
                edge_stamp = edge_stamp + dir_rows[i].interval;
                send_item(KIND_CAPTURE, edge_stamp, dir_rows[i].armed,
                          dir_rows[i].typed, dir_rows[i].want);
            end
            else
            begin
                send_item(KIND_TICK, TIME_W'($urandom), dir_rows[i].armed,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end
        run_random(1'b0);

        // phase 1: random registers, sender mostly idle
        drain();
        program_random();
        set_idle(IDLE_SENDER);
        run_random(1'b0);

        // phase 2: every register at its low end, receiver mostly stalled
        drain();
        program_regs(16'd1200, 16'd900, 16'd900, 16'd900, 16'd0, 16'd0, 16'd2100);
        set_idle(IDLE_RECEIVER);
        run_random(1'b0);

        // phase 3: every register at its high end, both sides idling
        drain();
        program_regs(16'd1800, 16'd2100, 16'd2100, 16'd2100, 16'd400, 16'd1000, 16'd65535);
        set_idle(IDLE_BOTH);
        run_random(1'b0);

        // phase 4: arm and disarm overlap, centre window below zero, masked and unused writes
        drain();
        raw_center       = 16'($urandom);
        raw_center[10:0] = 11'($urandom_range(399, 0));
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        program_regs(raw_center, 16'd2100, 16'd900, 16'd2100, 16'd400,
                     16'($urandom_range(3, 0)), 16'($urandom_range(65535, 2100)));
        set_idle(IDLE_NONE);
        run_random(1'b0);

        // phase 5: random registers, both sides idling, a full drain halfway
        drain();
        program_random();
        set_idle(IDLE_BOTH);
        run_random(1'b1);

        // phase 6: random registers, receiver mostly stalled
        drain();
        program_random();
        set_idle(IDLE_RECEIVER);
        run_random(1'b0);

        // wait for the last results and watch for strays
        drain();
        if (pending_results.size() != 0)
        begin
            err_count++;
            $display("error: %0d results never arrived", pending_results.size());
        end
        $display("covered %0d input and %0d result transactions, %0d register writes, %0d phases",
                 in_count, result_count, cfg_writes, NUM_PHASES);
        $display("seen: arm %0d, disarm %0d, frame sync %0d, stored pulse %0d, centered %0d",
                 arm_seen, disarm_seen, sync_seen, store_seen, center_seen);
        if (err_count == 0)
        begin
            $display("PASS ppm_decoder_with_arm_gesture");
        end
        else
        begin
            $display("%0d errors", err_count);
            $display("FAIL ppm_decoder_with_arm_gesture");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ppm_pkg.sv
rtl/core/ppm_front.sv
rtl/core/ppm_queue.sv
rtl/core/ppm_back.sv
rtl/core/ppm_decoder_with_arm_gesture.sv
test/ppm_decoder_with_arm_gesture_tb.sv
